// ===== rtl/ncp_pkg.sv =====
// Package for the complementarity residual error block: function codes,
// sequencer state type and fixed widths. No dependencies.
package ncp_pkg;

   localparam int ValueWidth = 32;
   localparam int FuncWidth  = 2;
   localparam int IndexWidth = 6;
   localparam int SizeWidth  = 7;

   typedef enum logic [1:0] {
      FUNC_LOAD_M = 2'd0,
      FUNC_LOAD_Q = 2'd1,
      FUNC_LOAD_Z = 2'd2,
      FUNC_CALC   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROOT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ValueWidth-1:0] error_ratio;
      logic                  zero_norm;
      logic                  saturated;
   } rsp_type;

endpackage

// ===== rtl/ncp_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface ncp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [5:0]  row_index;
   logic [5:0]  col_index;
   logic [31:0] value;
   modport source  (output valid, func, row_index, col_index, value, input ready);
   modport sink    (input valid, func, row_index, col_index, value, output ready);
   modport monitor (input valid, ready, func, row_index, col_index, value);
endinterface

interface ncp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] error_ratio;
   logic        zero_norm;
   logic        saturated;
   modport source  (output valid, error_ratio, zero_norm, saturated, input ready);
   modport sink    (input valid, error_ratio, zero_norm, saturated, output ready);
   modport monitor (input valid, ready, error_ratio, zero_norm, saturated);
endinterface

// ===== rtl/ncp_residual_error_top.sv =====
// Top level of the complementarity residual error block.
// Order of a compute: multiply-accumulate over the matrix memory read port, 37 square root
// steps, a divide set-up step, 31 divide steps and an output state; zero norm or saturation
// skip the divide steps. One item at a time: the input stalls while a computation runs
// and while a result waits.
// Reset (synchronous, active high) clears control, sets size_ff to 64; memories undefined.
module ncp_residual_error_top #(
   parameter int MAX_DIM   = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   ncp_req_if.sink      req,
   ncp_rsp_if.source    rsp,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data
);
   import ncp_pkg::*;
   localparam int AW = $clog2(MAX_DIM);
   localparam int CW = AW + 1;

   state_type state_ff, state_in;
   logic [6:0]  size_ff;
   logic [AW-1:0] row_ff, row_in, col_ff, col_in;
   logic        rd_vld_ff, last_col_ff, last_row_ff;
   logic        rsp_vld_ff;
   rsp_type     rsp_ff;
   logic [CW-1:0] n;

   logic signed [63:0]  s_ff;
   logic [127:0]        err_ff, sq_ff;
   logic [37:0]         root_ff;
   logic [127:0]        rsq_ff;
   logic [5:0]          bit_ff;
   logic [127:0]        rem_ff;
   logic [31:0]         quo_ff;
   logic                first_ff;

   logic [31:0] m_rd, zc_rd, q_rd, zr_rd;
   logic        wr_en;
   logic [CW-1:0] row_ext, col_ext;

   // dimension clamp
   always_comb begin
      if (size_ff == 7'd0) n = CW'(1);
      else if (int'(size_ff) > MAX_DIM) n = CW'(MAX_DIM);
      else n = CW'(size_ff);
   end

   assign req.ready = (state_ff == ST_IDLE) && !(rsp_vld_ff && !rsp.ready);
   assign wr_en     = req.valid && req.ready && req.func != FUNC_CALC &&
                      (int'(req.row_index) < MAX_DIM) &&
                      (int'(req.col_index) < MAX_DIM || req.func != FUNC_LOAD_M);

   ncp_store #(.MAX_DIM(MAX_DIM)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_func(func_type'(req.func)),
      .wr_row (AW'(req.row_index)),
      .wr_col (AW'(req.col_index)),
      .wr_data(req.value),
      .rd_row (row_ff),
      .rd_col (col_ff),
      .m_rd   (m_rd),
      .zc_rd  (zc_rd),
      .q_rd   (q_rd),
      .zr_rd  (zr_rd)
   );

   assign row_ext = CW'(row_ff) + CW'(1);
   assign col_ext = CW'(col_ff) + CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid && req.ready && req.func == FUNC_CALC) state_in = ST_MAC;
         ST_MAC:  if (rd_vld_ff && last_col_ff && last_row_ff) state_in = ST_ROOT;
         ST_ROOT: if (bit_ff == 6'd0) state_in = ST_DIV;
         ST_DIV:  if (first_ff ? (root_ff == '0 || lim <= dvd) : (bit_ff == 6'd0))
                     state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // read address walk
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (state_ff == ST_IDLE) begin
         row_in = '0;
         col_in = '0;
      end else if (state_ff == ST_MAC) begin
         if (col_ext == n) begin
            col_in = '0;
            if (row_ext != n) row_in = row_ff + AW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   logic signed [63:0] prod, s_cur, s_base;
   logic [31:0]  qmag;
   logic [63:0]  qsq;
   logic [127:0] cand_sq, lim, dvd, r2;
   logic [37:0]  cand;
   logic [63:0]  abs_s;

   assign prod   = $signed(m_rd) * $signed(zc_rd);
   assign s_base = first_ff ? (64'($signed(q_rd)) + 64'($signed(zr_rd))) : s_ff;
   assign s_cur  = s_base + (prod >>> FRAC_BITS);
   assign qmag   = q_rd[31] ? 32'(-q_rd) : q_rd;
   assign qsq    = qmag * qmag;
   assign abs_s  = 64'(-s_cur);
   assign cand   = root_ff | (38'd1 << bit_ff);
   // (root + 2^b)^2 = root^2 + root*2^(b+1) + 2^(2b)
   assign cand_sq = rsq_ff + (128'(root_ff) << (bit_ff + 6'd1)) +
                    (128'd1 << {bit_ff, 1'b0});
   assign dvd    = (err_ff << 1) << FRAC_BITS;
   assign lim    = 128'(root_ff) << 31;
   assign r2     = 128'(root_ff) << bit_ff;

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         size_ff     <= 7'd64;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) size_ff <= csr_wr_data;
         rd_vld_ff <= (state_ff == ST_MAC) && !(rd_vld_ff && last_col_ff && last_row_ff);
         if (state_ff == ST_DONE) rsp_vld_ff <= 1'b1;
         else if (rsp_vld_ff && rsp.ready) rsp_vld_ff <= 1'b0;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      last_col_ff <= (col_ext == n);
      last_row_ff <= (row_ext == n);
      case (state_ff)
         ST_IDLE: begin
            err_ff <= '0;
            sq_ff <= '0;
            first_ff <= 1'b1;
            root_ff <= '0;
            rsq_ff <= '0;
            bit_ff <= 6'd36;
         end
         ST_MAC: if (rd_vld_ff) begin
            if (last_col_ff) begin
               first_ff <= 1'b1;
               if (s_cur < 0) err_ff <= err_ff + 128'(abs_s);
               sq_ff <= sq_ff + 128'(qsq);
            end else begin
               first_ff <= 1'b0;
               s_ff <= s_cur;
            end
         end
         ST_ROOT: begin
            if (cand_sq <= sq_ff) begin
               root_ff <= cand;
               rsq_ff <= cand_sq;
            end
            if (bit_ff == 6'd0) begin
               bit_ff <= 6'd30;
               first_ff <= 1'b1;
            end else bit_ff <= bit_ff - 6'd1;
         end
         ST_DIV: begin
            if (first_ff) begin
               first_ff <= 1'b0;
               rem_ff <= dvd;
               quo_ff <= '0;
               if (root_ff == '0) begin
                  rsp_ff <= '{error_ratio: '0, zero_norm: 1'b1, saturated: 1'b0};
               end else if (lim <= dvd) begin
                  rsp_ff <= '{error_ratio: 32'h7FFF_FFFF, zero_norm: 1'b0,
                              saturated: 1'b1};
               end
            end else begin
               if (r2 <= rem_ff) begin
                  rem_ff <= rem_ff - r2;
                  quo_ff[bit_ff[4:0]] <= 1'b1;
               end
               if (bit_ff != 6'd0) bit_ff <= bit_ff - 6'd1;
            end
         end
         ST_DONE: if (root_ff != '0 && !(lim <= dvd))
            rsp_ff <= '{error_ratio: quo_ff, zero_norm: 1'b0, saturated: 1'b0};
         default: ;
      endcase
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.error_ratio = rsp_ff.error_ratio;
   assign rsp.zero_norm   = rsp_ff.zero_norm;
   assign rsp.saturated   = rsp_ff.saturated;
endmodule

// ===== rtl/ncp_store.sv =====
// Matrix, q and z memories, with synchronous (registered) read.
// Depends on ncp_pkg.
module ncp_store #(
   parameter int MAX_DIM = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  ncp_pkg::func_type             wr_func,
   input  logic [$clog2(MAX_DIM)-1:0]    wr_row,
   input  logic [$clog2(MAX_DIM)-1:0]    wr_col,
   input  logic [31:0]                   wr_data,
   input  logic [$clog2(MAX_DIM)-1:0]    rd_row,
   input  logic [$clog2(MAX_DIM)-1:0]    rd_col,
   output logic [31:0]                   m_rd,
   output logic [31:0]                   zc_rd,
   output logic [31:0]                   q_rd,
   output logic [31:0]                   zr_rd
);
   import ncp_pkg::*;
   localparam int AW = $clog2(MAX_DIM);

   // matrix addressed by {row, col}, so the depth covers the full index space
   logic [31:0] m_mem [2**(2*AW)];
   logic [31:0] q_mem [MAX_DIM];
   logic [31:0] z_mem [MAX_DIM];
   logic [31:0] z2_mem [MAX_DIM];

   // matrix memory
   always_ff @(posedge clock) begin
      if (wr_en && wr_func == FUNC_LOAD_M) m_mem[{wr_row, wr_col}] <= wr_data;
      m_rd <= m_mem[{rd_row, rd_col}];
   end

   // q memory
   always_ff @(posedge clock) begin
      if (wr_en && wr_func == FUNC_LOAD_Q) q_mem[wr_row] <= wr_data;
      q_rd <= q_mem[rd_row];
   end

   // z held twice: column read and row read
   always_ff @(posedge clock) begin
      if (wr_en && wr_func == FUNC_LOAD_Z) begin
         z_mem[wr_row]  <= wr_data;
         z2_mem[wr_row] <= wr_data;
      end
      zc_rd <= z_mem[rd_col];
      zr_rd <= z2_mem[rd_row];
   end
endmodule
